>>> rtl/core/tmsgp_pkg.sv
// Shared types, character codes and character classifier functions for the
// text message parser. Depends on nothing; every other file uses it.
package tmsgp_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 3;
   localparam int NIB_W  = 4;

   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_R     = 8'h52;
   localparam logic [CHAR_W-1:0] CHAR_S     = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_D     = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_E     = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_P     = 8'h50;
   localparam logic [CHAR_W-1:0] CHAR_K     = 8'h4B;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LF_HEX = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 3'd0,
      KIND_SET   = 3'd1,
      KIND_DATA  = 3'd2,
      KIND_END   = 3'd3,
      KIND_POLL  = 3'd4,
      KIND_ECHO  = 3'd5
   } kind_type;

   typedef struct packed {
      logic                emit;
      logic [KIND_W-1:0]   kind;
      logic [CHAR_W-1:0]   data;
   } result_type;

   typedef struct packed {
      logic                hit;
      logic [KIND_W-1:0]   code;
   } kind_match_type;

   typedef struct packed {
      logic                hit;
      logic [NIB_W-1:0]    nib;
   } hex_match_type;

   function automatic logic is_white(input logic [CHAR_W-1:0] c);
      logic r;
      case (c) inside
         CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_separator(input logic [CHAR_W-1:0] c);
      return (c == CHAR_COMMA) || (c == CHAR_SEMI) || is_white(c);
   endfunction

   function automatic kind_match_type kind_of(input logic [CHAR_W-1:0] c);
      kind_match_type r;
      r.hit = 1'b1;
      case (c)
         CHAR_R:  r.code = KIND_CLEAR;
         CHAR_S:  r.code = KIND_SET;
         CHAR_D:  r.code = KIND_DATA;
         CHAR_E:  r.code = KIND_END;
         CHAR_P:  r.code = KIND_POLL;
         CHAR_K:  r.code = KIND_ECHO;
         default: begin
            r.hit  = 1'b0;
            r.code = KIND_CLEAR;
         end
      endcase
      return r;
   endfunction

   function automatic hex_match_type hex_of(input logic [CHAR_W-1:0] c);
      hex_match_type r;
      logic [CHAR_W-1:0] d;
      r.hit = 1'b1;
      d = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         d = c - CHAR_LA + 8'd10;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA + 8'd10;
      end else begin
         r.hit = 1'b0;
      end
      r.nib = d[NIB_W-1:0];
      return r;
   endfunction

endpackage

>>> rtl/core/tmsgp_in_stage.sv
// Input register of the text message parser: holds one received character.
// Depends on tmsgp_pkg.
module tmsgp_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         drain,
   input  logic [tmsgp_pkg::CHAR_W-1:0] char_in,
   output logic                         valid,
   output logic [tmsgp_pkg::CHAR_W-1:0] char_out
);

   logic                         valid_ff, valid_in;
   logic [tmsgp_pkg::CHAR_W-1:0] char_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
      end
   end

   assign valid    = valid_ff;
   assign char_out = char_ff;

endmodule

>>> rtl/core/tmsgp_step.sv
// Parser state machine: phase, held kind and held value, advanced by one
// character per step. Depends on tmsgp_pkg.
module tmsgp_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [tmsgp_pkg::CHAR_W-1:0] char_in,
   output tmsgp_pkg::result_type        result
);

   typedef enum logic [2:0] {
      PH_LETTER = 3'd0,
      PH_COLON  = 3'd1,
      PH_HEX1   = 3'd2,
      PH_HEX2   = 3'd3,
      PH_SEP    = 3'd4,
      PH_SKIP   = 3'd5
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [tmsgp_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [tmsgp_pkg::CHAR_W-1:0] value_ff, value_in;
   tmsgp_pkg::kind_match_type    km;
   tmsgp_pkg::hex_match_type     hm;
   logic                         sep;

   always_comb begin
      km       = tmsgp_pkg::kind_of(char_in);
      hm       = tmsgp_pkg::hex_of(char_in);
      sep      = tmsgp_pkg::is_separator(char_in);
      phase_in = phase_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      result.emit = 1'b0;
      result.kind = kind_ff;
      result.data = value_ff;
      unique case (phase_ff)
         PH_LETTER: begin
            if (km.hit) begin
               kind_in  = km.code;
               phase_in = PH_COLON;
            end else if (!tmsgp_pkg::is_white(char_in)) begin
               phase_in = PH_SKIP;
            end
         end
         PH_COLON: begin
            phase_in = (char_in == tmsgp_pkg::CHAR_COLON) ? PH_HEX1 : PH_SKIP;
         end
         PH_HEX1: begin
            if (hm.hit) begin
               value_in = {{(tmsgp_pkg::CHAR_W-tmsgp_pkg::NIB_W){1'b0}}, hm.nib};
               phase_in = PH_HEX2;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_HEX2: begin
            if (hm.hit) begin
               value_in = {value_ff[tmsgp_pkg::NIB_W-1:0], hm.nib};
               phase_in = PH_SEP;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_SEP: begin
            if (sep) begin
               result.emit = 1'b1;
               phase_in    = PH_LETTER;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (sep) begin
               phase_in = PH_LETTER;
            end
         end
         default: begin
            phase_in = PH_LETTER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LETTER;
         kind_ff  <= '0;
         value_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         value_ff <= value_in;
      end
   end

endmodule

>>> rtl/core/tmsgp_out_stage.sv
// Result register of the text message parser: holds one parsed message
// until the receiver takes it. Depends on tmsgp_pkg.
module tmsgp_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  tmsgp_pkg::result_type        result,
   input  logic                         stall,
   output logic                         valid,
   output logic [tmsgp_pkg::KIND_W-1:0] msg_kind,
   output logic [tmsgp_pkg::CHAR_W-1:0] data_byte
);

   logic                         valid_ff, valid_in;
   logic [tmsgp_pkg::KIND_W-1:0] kind_ff;
   logic [tmsgp_pkg::CHAR_W-1:0] data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = result.emit;
      end else if (!stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.emit) begin
         kind_ff <= result.kind;
         data_ff <= result.data;
      end
   end

   assign valid     = valid_ff;
   assign msg_kind  = kind_ff;
   assign data_byte = data_ff;

endmodule

>>> rtl/core/text_message_parser_unit.sv
// Top level of the text message parser: input register, parser step and
// result register. Depends on tmsgp_pkg, tmsgp_in_stage, tmsgp_step, tmsgp_out_stage.
//
//   channel   direction   ports
//   request   in          req_valid, req_stall, req_char_in
//   response  out         rsp_valid, rsp_stall, rsp_msg_kind, rsp_data_byte
//
// One character is accepted per cycle while req_stall is low; a message is in the
// result register once the parser step has advanced on its separator character.
// Reset is synchronous and returns the parser to waiting for a message letter.
// A stalled response holds the parser step; req_stall rises only while the
// input register is full and the step cannot move.
module text_message_parser_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tmsgp_pkg::CHAR_W-1:0] req_char_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tmsgp_pkg::KIND_W-1:0] rsp_msg_kind,
   output logic [tmsgp_pkg::CHAR_W-1:0] rsp_data_byte
);

   logic                         in_valid;
   logic [tmsgp_pkg::CHAR_W-1:0] in_char;
   logic                         advance;
   logic                         accept;
   tmsgp_pkg::result_type        step_result;

   assign advance   = in_valid && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid && !advance;
   assign accept    = req_valid && !req_stall;

   tmsgp_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .drain    (advance),
      .char_in  (req_char_in),
      .valid    (in_valid),
      .char_out (in_char)
   );

   tmsgp_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .char_in (in_char),
      .result  (step_result)
   );

   tmsgp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (step_result),
      .stall     (rsp_stall),
      .valid     (rsp_valid),
      .msg_kind  (rsp_msg_kind),
      .data_byte (rsp_data_byte)
   );

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid)
      else $error("request stalled with an empty input register");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance && step_result.emit))
      else $error("response appeared without a completed message");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_msg_kind <= tmsgp_pkg::KIND_ECHO))
      else $error("response carries an undefined message kind");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !advance)
      else $error("parser advanced while a stalled response was held");
`endif

endmodule

>>> bench/text_message_parser_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for text_message_parser_unit: feeds character streams, predicts
// every parsed message and compares each response. Depends on tmsgp_pkg and the RTL.
module text_message_parser_unit_test;
   import tmsgp_pkg::*;

   typedef enum logic [2:0] {
      PH_LETTER = 3'd0,
      PH_COLON  = 3'd1,
      PH_HEX1   = 3'd2,
      PH_HEX2   = 3'd3,
      PH_SEP    = 3'd4,
      PH_SKIP   = 3'd5
   } scan_phase_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] value;
   } message_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CHAR_W-1:0] req_char_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [KIND_W-1:0] rsp_msg_kind;
   logic [CHAR_W-1:0] rsp_data_byte;

   scan_phase_type    scan_phase;
   kind_type          kind_seen;
   logic [CHAR_W-1:0] value_built;
   message_type       pending_messages[$];
   int unsigned       error_count = 0;
   int unsigned       counted_chars = 0;
   bit                sender_gaps = 1'b0;
   bit                receiver_stalls = 1'b0;

   text_message_parser_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_in   (req_char_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_msg_kind  (rsp_msg_kind),
      .rsp_data_byte (rsp_data_byte)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
   endfunction

   function automatic bit is_delim(input logic [CHAR_W-1:0] c);
      return c == CHAR_COMMA || c == CHAR_SEMI || is_blank(c);
   endfunction

   function automatic bit hex_digit(input logic [CHAR_W-1:0] c, output logic [NIB_W-1:0] nib);
      logic [CHAR_W-1:0] offset;
      offset = '0;
      nib = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         offset = c - CHAR_0;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         offset = c - CHAR_UA + 8'd10;
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         offset = c - CHAR_LA + 8'd10;
      end else begin
         return 1'b0;
      end
      nib = offset[NIB_W-1:0];
      return 1'b1;
   endfunction

   function automatic bit letter_kind(input logic [CHAR_W-1:0] c, output kind_type k);
      k = KIND_CLEAR;
      case (c)
         CHAR_R: k = KIND_CLEAR;
         CHAR_S: k = KIND_SET;
         CHAR_D: k = KIND_DATA;
         CHAR_E: k = KIND_END;
         CHAR_P: k = KIND_POLL;
         CHAR_K: k = KIND_ECHO;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Advances the expected parser state by one character and queues any
   // completed message.
   function automatic void advance_parser(input logic [CHAR_W-1:0] c);
      logic [NIB_W-1:0] nib;
      kind_type         k;
      case (scan_phase)
         PH_LETTER: begin
            if (letter_kind(c, k)) begin
               kind_seen = k;
               scan_phase = PH_COLON;
            end else if (!is_blank(c)) begin
               scan_phase = PH_SKIP;
            end
         end
         PH_COLON: begin
            if (c == CHAR_COLON) scan_phase = PH_HEX1;
            else scan_phase = PH_SKIP;
         end
         PH_HEX1: begin
            if (hex_digit(c, nib)) begin
               value_built = {4'h0, nib};
               scan_phase = PH_HEX2;
            end else begin
               scan_phase = PH_SKIP;
            end
         end
         PH_HEX2: begin
            if (hex_digit(c, nib)) begin
               value_built = {value_built[NIB_W-1:0], nib};
               scan_phase = PH_SEP;
            end else begin
               scan_phase = PH_SKIP;
            end
         end
         PH_SEP: begin
            if (is_delim(c)) begin
               pending_messages.push_back(message_type'{kind_seen, value_built});
               scan_phase = PH_LETTER;
            end else begin
               scan_phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (is_delim(c)) scan_phase = PH_LETTER;
         end
         default: scan_phase = PH_LETTER;
      endcase
   endfunction

   task automatic send_char(input logic [CHAR_W-1:0] c);
      int unsigned gap;
      gap = sender_gaps ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      do begin
         @(posedge clock);
      end while (req_stall);
      advance_parser(c);
      counted_chars++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic logic [CHAR_W-1:0] pick_letter();
      case ($urandom_range(0, 5))
         0: return CHAR_R;
         1: return CHAR_S;
         2: return CHAR_D;
         3: return CHAR_E;
         4: return CHAR_P;
         default: return CHAR_K;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pick_hex();
      logic [CHAR_W-1:0] nib;
      nib = CHAR_W'($urandom_range(0, 15));
      if (nib < 10) return CHAR_0 + nib;
      return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + nib - 8'd10;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_delim();
      case ($urandom_range(0, 5))
         0: return CHAR_COMMA;
         1: return CHAR_SEMI;
         2: return CHAR_SPACE;
         3: return CHAR_TAB;
         4: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // Sends one message, after up to two leading blanks, cut short after the given number
   // of characters and followed by a random byte and a separator when cut below five.
   task automatic send_message(input int unsigned cut);
      logic [CHAR_W-1:0] chars[5];
      chars[0] = pick_letter();
      chars[1] = CHAR_COLON;
      chars[2] = pick_hex();
      chars[3] = pick_hex();
      chars[4] = pick_delim();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
         send_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      end
      for (int i = 0; i < cut; i++) send_char(chars[i]);
      if (cut < 5) begin
         send_char(CHAR_W'($urandom_range(0, 255)));
         send_char(pick_delim());
      end
   endtask

   task automatic test_each_kind();
      send_text("R:00,");
      send_text("K:fF");
      send_char(CHAR_LF);
      send_text(" S:A0;");
      send_text("D:5c");
      send_char(CHAR_TAB);
   endtask

   task automatic test_special_cases();
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      send_text("Z");
      send_char(CHAR_TAB);
      send_text(";");
      send_char(CHAR_CR);
      send_text("E:g ");
      send_text("P:9");
      send_char(8'hFF);
      send_text(",");
      send_char(8'h80);
      send_text("E:3B,");
   endtask

   task automatic test_random_stream();
      int unsigned start_count;
      int unsigned round;
      int unsigned choice;
      start_count = counted_chars;
      round = 0;
      while (counted_chars - start_count < 1300) begin
         if (round % 20 == 0) {sender_gaps, receiver_stalls} = 2'($urandom_range(0, 3));
         round++;
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            send_message(5);
         end else if (choice < 9) begin
            send_message($urandom_range(1, 4));
         end else begin
            repeat ($urandom_range(1, 4)) send_char(CHAR_W'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic report_error(input bit have_want, input message_type want);
      error_count++;
      if (error_count <= 10) begin
         if (have_want) begin
            $display("%0t: message mismatch: expected kind %0d byte %h, got kind %0d byte %h",
               $time, want.kind, want.value, rsp_msg_kind, rsp_data_byte);
         end else begin
            $display("%0t: unexpected message: kind %0d byte %h",
               $time, rsp_msg_kind, rsp_data_byte);
         end
      end
   endtask

   initial begin
      int unsigned hold;
      message_type want;
      rsp_stall <= 1'b0;
      forever begin
         hold = receiver_stalls ? $urandom_range(0, 17) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do begin
            @(posedge clock);
         end while (rsp_valid !== 1'b1 || reset);
         if (pending_messages.size() == 0) begin
            report_error(1'b0, '0);
         end else begin
            want = pending_messages.pop_front();
            if (rsp_msg_kind !== want.kind || rsp_data_byte !== want.value) begin
               report_error(1'b1, want);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_in <= '0;
      scan_phase = PH_LETTER;
      kind_seen = KIND_CLEAR;
      value_built = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_each_kind();
      test_special_cases();
      test_random_stream();
      req_valid <= 1'b0;
      while (pending_messages.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (error_count == 0) begin
         $display("text_message_parser_unit_test: done, clean");
      end else begin
         $display("text_message_parser_unit_test: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("text_message_parser_unit_test: done, errors");
      $finish;
   end

endmodule
